// ===== sv/ud128_pkg.sv =====
package ud128_pkg;

	localparam int WordW   = 64;
	localparam int NumBits = 2 * WordW;
	localparam int CntW    = $clog2(NumBits);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

endpackage

// ===== sv/unsigned_divide_128.sv =====
// channel   valid      stall      payload
// div       div_valid  div_stall  dividend_hi, dividend_lo, divisor_hi, divisor_lo
// res       res_valid  res_stall  quotient_hi, quotient_lo, remainder_hi, remainder_lo, status
//
// one word at a time: one shift-and-subtract step per quotient bit (128), through the
// single 130-bit subtractor; the word is taken in idle, and the hold state hands the
// result to the output register once that register is free.
// arst_n clears the sequencer and the result valid; datapath registers are not reset.
// div_stall is high from the cycle after a word is taken until its result is loaded.
// a waiting result holds the output register; the next divide still starts meanwhile.
module unsigned_divide_128 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          div_valid,
	output logic                          div_stall,
	input  logic [ud128_pkg::WordW-1:0]   dividend_hi,
	input  logic [ud128_pkg::WordW-1:0]   dividend_lo,
	input  logic [ud128_pkg::WordW-1:0]   divisor_hi,
	input  logic [ud128_pkg::WordW-1:0]   divisor_lo,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [ud128_pkg::WordW-1:0]   quotient_hi,
	output logic [ud128_pkg::WordW-1:0]   quotient_lo,
	output logic [ud128_pkg::WordW-1:0]   remainder_hi,
	output logic [ud128_pkg::WordW-1:0]   remainder_lo,
	output logic                          status
);

	localparam int NB = ud128_pkg::NumBits;
	localparam int WW = ud128_pkg::WordW;

	ud128_pkg::state_t           state_q;
	logic [ud128_pkg::CntW-1:0]  cnt_q;
	logic [NB-1:0]               rem_q;
	// dividend bits shift out at the top while quotient bits fill in at the bottom
	logic [NB-1:0]               quo_q;
	logic [NB-1:0]               dvs_q;
	logic                        err_q;

	logic                        res_valid_q;
	logic [NB-1:0]               res_quo_q;
	logic [NB-1:0]               res_rem_q;
	logic                        res_err_q;

	logic [NB:0]                 rem_shift;
	logic [NB+1:0]               diff;
	logic                        take;
	logic                        div_acc;
	logic                        out_free;
	logic                        out_load;

	assign div_acc   = div_valid && (state_q == ud128_pkg::ST_IDLE);
	assign div_stall = (state_q != ud128_pkg::ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign out_load  = (state_q == ud128_pkg::ST_HOLD) && out_free;

	always_comb begin
		rem_shift = {rem_q, quo_q[NB-1]};
		diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
		take      = !diff[NB+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ud128_pkg::ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ud128_pkg::ST_IDLE: begin
					if (div_valid) begin
						state_q <= ud128_pkg::ST_CALC;
						cnt_q   <= ud128_pkg::CntW'(NB - 1);
					end
				end
				ud128_pkg::ST_CALC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ud128_pkg::ST_HOLD;
					end
				end
				ud128_pkg::ST_HOLD: begin
					if (out_free) begin
						state_q <= ud128_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ud128_pkg::ST_IDLE;
				end
			endcase
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_acc) begin
			rem_q <= '0;
			quo_q <= {dividend_hi, dividend_lo};
			dvs_q <= {divisor_hi, divisor_lo};
			err_q <= ({divisor_hi, divisor_lo} == '0);
		end else if (state_q == ud128_pkg::ST_CALC) begin
			rem_q <= take ? diff[NB-1:0] : rem_shift[NB-1:0];
			quo_q <= {quo_q[NB-2:0], take};
		end
		if (out_load) begin
			res_quo_q <= err_q ? '0 : quo_q;
			res_rem_q <= err_q ? '0 : rem_q;
			res_err_q <= err_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign quotient_hi  = res_quo_q[NB-1:WW];
	assign quotient_lo  = res_quo_q[WW-1:0];
	assign remainder_hi = res_rem_q[NB-1:WW];
	assign remainder_lo = res_rem_q[WW-1:0];
	assign status       = res_err_q;

endmodule

// ===== sv/ud128_chk.sv =====
module ud128_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        div_valid,
	input logic                        div_stall,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [ud128_pkg::WordW-1:0] quotient_hi,
	input logic [ud128_pkg::WordW-1:0] quotient_lo,
	input logic [ud128_pkg::WordW-1:0] remainder_hi,
	input logic [ud128_pkg::WordW-1:0] remainder_lo,
	input logic                        status
);

	// a taken word keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !div_stall |=> div_stall)
		else $error("divide word taken but block not busy");

	// a result only appears at the end of a divide
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(div_stall))
		else $error("result word without a divide in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status |-> quotient_hi == '0 && quotient_lo == '0
			&& remainder_hi == '0 && remainder_lo == '0)
		else $error("divide by zero with nonzero result fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(quotient_lo) && $stable(remainder_lo))
		else $error("stalled result word changed");

endmodule

bind unsigned_divide_128 ud128_chk u_ud128_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.div_valid    (div_valid),
	.div_stall    (div_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.quotient_hi  (quotient_hi),
	.quotient_lo  (quotient_lo),
	.remainder_hi (remainder_hi),
	.remainder_lo (remainder_lo),
	.status       (status)
);
